>>> rtl/core/field_table_lookup_macros.svh
// Assertion macros used by the checker file.
`ifndef FIELD_TABLE_LOOKUP_MACROS_SVH
`define FIELD_TABLE_LOOKUP_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define FTL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define FTL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/ftl_pkg.sv
`default_nettype none
package ftl_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = 9;
	localparam int NUM_W       = 29;
	localparam int PRES_W      = 16;
	localparam int ENTRY_W     = NUM_W + PRES_W;
	localparam int REQ_W       = 2;
	localparam int CFG_IDX_W   = 1;

	localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FIND = 2'd1;
	localparam logic [REQ_W-1:0] REQ_GET  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_NEXT = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_DENSE_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'd1;

	localparam logic [1:0] RD_SRC_INPUT = 2'd0;
	localparam logic [1:0] RD_SRC_CUR   = 2'd1;
	localparam logic [1:0] RD_SRC_MID   = 2'd2;

	typedef struct packed {
		logic       accept;
		logic       wr_en;
		logic       rd_en;
		logic [1:0] rd_src;
		logic       code_load;
		logic       scan_from_zero;
		logic       mid_load;
		logic       srch_step;
		logic       cur_inc;
		logic       cap_hit;
		logic       cap_miss;
		logic       out_load;
	} ftl_cmd_t;

	typedef struct packed {
		logic dense_hit;
		logic given_oor;
		logic given_member;
		logic scan_more;
		logic scan_match;
		logic srch_more;
		logic srch_eq;
		logic out_free;
	} ftl_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/ftl_ram.sv
`default_nettype none
module ftl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/ftl_dp.sv
`default_nettype none
module ftl_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [ftl_pkg::REQ_W-1:0]           req_type,
	input  wire logic [ftl_pkg::IDX_W-1:0]           entry_index,
	input  wire logic [ftl_pkg::NUM_W-1:0]           field_number,
	input  wire logic signed [ftl_pkg::PRES_W-1:0]   presence,
	input  wire logic                                cfg_we,
	input  wire logic [ftl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [ftl_pkg::CNT_W-1:0]           cfg_wdata,
	input  wire logic                                out_stall,
	input  wire ftl_pkg::ftl_cmd_t                   cmd,
	output ftl_pkg::ftl_stat_t                       stat,
	output logic                                     out_valid,
	output logic                                     found,
	output logic [ftl_pkg::IDX_W-1:0]                match_index,
	output logic [ftl_pkg::NUM_W-1:0]                match_number,
	output logic signed [ftl_pkg::PRES_W-1:0]        match_presence
);

	logic [ftl_pkg::CNT_W-1:0]          dense_q;
	logic [ftl_pkg::CNT_W-1:0]          count_q;
	logic [ftl_pkg::CNT_W-1:0]          eff_cnt;
	logic [ftl_pkg::CNT_W-1:0]          eff_dense;
	logic [ftl_pkg::NUM_W-1:0]          num_q;
	logic [ftl_pkg::IDX_W-1:0]          idx_q;
	logic [ftl_pkg::CNT_W-1:0]          cur_q;
	logic signed [ftl_pkg::CNT_W:0]     lo_q;
	logic signed [ftl_pkg::CNT_W:0]     hi_q;
	logic [ftl_pkg::CNT_W:0]            sum;
	logic [ftl_pkg::IDX_W-1:0]          mid;
	logic [ftl_pkg::PRES_W-1:0]         code_q;
	logic [ftl_pkg::IDX_W-1:0]          raddr;
	logic [ftl_pkg::IDX_W-1:0]          dense_addr;
	logic [ftl_pkg::ENTRY_W-1:0]        rdata;
	logic [ftl_pkg::NUM_W-1:0]          rd_num;
	logic [ftl_pkg::PRES_W-1:0]         rd_pres;
	logic                               res_found_q;
	logic [ftl_pkg::IDX_W-1:0]          res_index_q;
	logic [ftl_pkg::NUM_W-1:0]          res_number_q;
	logic [ftl_pkg::PRES_W-1:0]         res_presence_q;
	logic                               out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dense_q <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ftl_pkg::CFG_DENSE_LIMIT: dense_q <= cfg_wdata;
				ftl_pkg::CFG_ENTRY_COUNT: count_q <= cfg_wdata;
			endcase
		end
	end

	assign eff_cnt   = (count_q > ftl_pkg::CNT_W'(ftl_pkg::MAX_ENTRIES))
	                 ? ftl_pkg::CNT_W'(ftl_pkg::MAX_ENTRIES) : count_q;
	assign eff_dense = (dense_q > eff_cnt) ? eff_cnt : dense_q;

	// dense window covers numbers one up to the dense limit
	assign dense_addr = field_number[ftl_pkg::IDX_W-1:0] - ftl_pkg::IDX_W'(1);
	assign sum        = lo_q + hi_q;
	assign mid        = sum[ftl_pkg::IDX_W:1];

	always_comb begin
		unique case (cmd.rd_src)
			ftl_pkg::RD_SRC_INPUT: raddr = (req_type == ftl_pkg::REQ_FIND) ? dense_addr : entry_index;
			ftl_pkg::RD_SRC_MID:   raddr = mid;
			default:               raddr = cur_q[ftl_pkg::IDX_W-1:0];
		endcase
	end

	ftl_ram #(
		.WIDTH(ftl_pkg::ENTRY_W),
		.DEPTH(ftl_pkg::MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (entry_index),
		.wdata ({field_number, presence}),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_num  = rdata[ftl_pkg::ENTRY_W-1:ftl_pkg::PRES_W];
	assign rd_pres = rdata[ftl_pkg::PRES_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			num_q <= field_number;
			idx_q <= entry_index;
			cur_q <= {1'b0, dense_addr};
			lo_q  <= $signed({1'b0, eff_dense});
			hi_q  <= $signed({1'b0, eff_cnt}) - 10'sd1;
		end
		if (cmd.code_load) begin
			code_q <= rd_pres;
			cur_q  <= cmd.scan_from_zero ? '0 : ({1'b0, idx_q} + ftl_pkg::CNT_W'(1));
		end
		if (cmd.mid_load) begin
			cur_q <= {1'b0, mid};
		end
		if (cmd.cur_inc) begin
			cur_q <= cur_q + ftl_pkg::CNT_W'(1);
		end
		if (cmd.srch_step) begin
			if (rd_num < num_q) begin
				lo_q <= $signed({1'b0, cur_q}) + 10'sd1;
			end else begin
				hi_q <= $signed({1'b0, cur_q}) - 10'sd1;
			end
		end
		if (cmd.cap_hit) begin
			res_found_q    <= 1'b1;
			res_index_q    <= cur_q[ftl_pkg::IDX_W-1:0];
			res_number_q   <= rd_num;
			res_presence_q <= rd_pres;
		end
		if (cmd.cap_miss) begin
			res_found_q    <= 1'b0;
			res_index_q    <= '0;
			res_number_q   <= '0;
			res_presence_q <= '0;
		end
		if (cmd.out_load) begin
			found          <= res_found_q;
			match_index    <= res_index_q;
			match_number   <= res_number_q;
			match_presence <= $signed(res_presence_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	assign stat.dense_hit    = (field_number != '0) && (field_number <= ftl_pkg::NUM_W'(eff_dense));
	assign stat.given_oor    = ({1'b0, entry_index} >= eff_cnt);
	assign stat.given_member = rd_pres[ftl_pkg::PRES_W-1];
	assign stat.scan_more    = (cur_q < eff_cnt);
	assign stat.scan_match   = (rd_pres == code_q);
	assign stat.srch_more    = (lo_q <= hi_q);
	assign stat.srch_eq      = (rd_num == num_q);
	assign stat.out_free     = !out_valid_q || !out_stall;

endmodule
`default_nettype wire

>>> rtl/core/ftl_ctrl.sv
`default_nettype none
module ftl_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic [ftl_pkg::REQ_W-1:0] req_type,
	input  wire ftl_pkg::ftl_stat_t        stat,
	output ftl_pkg::ftl_cmd_t              cmd,
	output logic                           in_stall
);

	localparam logic [3:0] S_IDLE       = 4'd0;
	localparam logic [3:0] S_HIT        = 4'd1;
	localparam logic [3:0] S_GIVEN_GET  = 4'd2;
	localparam logic [3:0] S_GIVEN_NEXT = 4'd3;
	localparam logic [3:0] S_SCAN       = 4'd4;
	localparam logic [3:0] S_SCAN_EV    = 4'd5;
	localparam logic [3:0] S_SRCH       = 4'd6;
	localparam logic [3:0] S_SRCH_EV    = 4'd7;
	localparam logic [3:0] S_DONE       = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	always_comb begin
		cmd       = '0;
		cmd.rd_src = ftl_pkg::RD_SRC_CUR;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.rd_src = ftl_pkg::RD_SRC_INPUT;
				if (in_valid) begin
					cmd.rd_en = 1'b1;
					unique case (req_type)
						ftl_pkg::REQ_LOAD: cmd.wr_en = 1'b1;
						ftl_pkg::REQ_FIND: begin
							cmd.accept = 1'b1;
							state_nxt  = stat.dense_hit ? S_HIT : S_SRCH;
						end
						ftl_pkg::REQ_GET: begin
							cmd.accept = 1'b1;
							cmd.cap_miss = stat.given_oor;
							state_nxt  = stat.given_oor ? S_DONE : S_GIVEN_GET;
						end
						ftl_pkg::REQ_NEXT: begin
							cmd.accept = 1'b1;
							cmd.cap_miss = stat.given_oor;
							state_nxt  = stat.given_oor ? S_DONE : S_GIVEN_NEXT;
						end
					endcase
				end
			end
			S_HIT: begin
				cmd.cap_hit = 1'b1;
				state_nxt   = S_DONE;
			end
			S_GIVEN_GET: begin
				if (stat.given_member) begin
					cmd.code_load      = 1'b1;
					cmd.scan_from_zero = 1'b1;
					state_nxt          = S_SCAN;
				end else begin
					cmd.cap_miss = 1'b1;
					state_nxt    = S_DONE;
				end
			end
			S_GIVEN_NEXT: begin
				cmd.code_load = 1'b1;
				state_nxt     = S_SCAN;
			end
			S_SCAN: begin
				if (stat.scan_more) begin
					cmd.rd_en = 1'b1;
					state_nxt = S_SCAN_EV;
				end else begin
					cmd.cap_miss = 1'b1;
					state_nxt    = S_DONE;
				end
			end
			S_SCAN_EV: begin
				if (stat.scan_match) begin
					cmd.cap_hit = 1'b1;
					state_nxt   = S_DONE;
				end else begin
					cmd.cur_inc = 1'b1;
					state_nxt   = S_SCAN;
				end
			end
			S_SRCH: begin
				cmd.rd_src = ftl_pkg::RD_SRC_MID;
				if (stat.srch_more) begin
					cmd.rd_en    = 1'b1;
					cmd.mid_load = 1'b1;
					state_nxt    = S_SRCH_EV;
				end else begin
					cmd.cap_miss = 1'b1;
					state_nxt    = S_DONE;
				end
			end
			S_SRCH_EV: begin
				if (stat.srch_eq) begin
					cmd.cap_hit = 1'b1;
					state_nxt   = S_DONE;
				end else begin
					cmd.srch_step = 1'b1;
					state_nxt     = S_SRCH;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule
`default_nettype wire

>>> rtl/core/field_table_lookup.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  req_type, entry_index, field_number, presence
// out       output     out_valid / out_stall found, match_index, match_number, match_presence
// cfg       input      cfg_we               cfg_index, cfg_wdata
//
// One item is in flight at a time; the controller walks the single read port of the
// entry RAM, with a read state and an evaluate state per probe.
// Load: no result. Dense find: hit captured in the hit state, then registered on output.
// Binary search: up to 9 probes over 256 entries.
// Oneof scans walk the entries in order. Reset clears control and config, not the RAM.
// A stalled result holds in the output register; the next item is taken meanwhile.
`default_nettype none
module field_table_lookup (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [ftl_pkg::REQ_W-1:0]           req_type,
	input  wire logic [ftl_pkg::IDX_W-1:0]           entry_index,
	input  wire logic [ftl_pkg::NUM_W-1:0]           field_number,
	input  wire logic signed [ftl_pkg::PRES_W-1:0]   presence,
	input  wire logic                                cfg_we,
	input  wire logic [ftl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [ftl_pkg::CNT_W-1:0]           cfg_wdata,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     found,
	output logic [ftl_pkg::IDX_W-1:0]                match_index,
	output logic [ftl_pkg::NUM_W-1:0]                match_number,
	output logic signed [ftl_pkg::PRES_W-1:0]        match_presence
);

	// command and status between sequencer and datapath
	ftl_pkg::ftl_cmd_t  cmd;
	ftl_pkg::ftl_stat_t stat;

	// sequencer: accept items, step search or scan, hand result to output
	ftl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// datapath: config registers, entry RAM, search bounds, cursor, result registers
	ftl_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_type       (req_type),
		.entry_index    (entry_index),
		.field_number   (field_number),
		.presence       (presence),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.out_stall      (out_stall),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.found          (found),
		.match_index    (match_index),
		.match_number   (match_number),
		.match_presence (match_presence)
	);

endmodule
`default_nettype wire

>>> rtl/core/ftl_checker.sv
`default_nettype none
`include "field_table_lookup_macros.svh"
module ftl_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_stall,
	input wire logic [ftl_pkg::REQ_W-1:0]           req_type,
	input wire logic                                out_valid,
	input wire logic                                out_stall,
	input wire logic                                found,
	input wire logic [ftl_pkg::IDX_W-1:0]           match_index,
	input wire logic [ftl_pkg::NUM_W-1:0]           match_number,
	input wire logic signed [ftl_pkg::PRES_W-1:0]   match_presence
);

	// a stalled result holds
	`FTL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(found) && $stable(match_index) && $stable(match_number) && $stable(match_presence), "stalled result changed")

	// lookups keep the block busy; loads do not
	`FTL_ASSERT_NEXT(a_lookup_busy, in_valid && !in_stall && (req_type != ftl_pkg::REQ_LOAD), in_stall, "lookup did not occupy the block")
	`FTL_ASSERT_NEXT(a_load_free, in_valid && !in_stall && (req_type == ftl_pkg::REQ_LOAD), !in_stall, "load left the block busy")

	// a miss carries all-zero fields
	`FTL_ASSERT(a_miss_zero, (out_valid && !found) |-> ((match_index == 0) && (match_number == 0) && (match_presence == 0)), "miss with nonzero fields")

	// a new result only follows a busy cycle
	`FTL_ASSERT(a_result_from_work, $rose(out_valid) |-> $past(in_stall), "result without work")

endmodule

bind field_table_lookup ftl_checker u_ftl_checker (.*);
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import ftl_pkg::*;

	localparam int  HALF_PERIOD  = 6;
	localparam int  RESET_CYCLES = 7;
	localparam int  DRAIN_CYCLES = 20;        // lets trailing loads and results drain
	localparam int  HOLD_CYCLES  = 400;       // long receiver hold-off
	localparam int  CYCLE_LIMIT  = 3_000_000;
	localparam int  PHASES       = 9;
	localparam int  PHASE_ITEMS  = 52;
	localparam int  REPORT_LIMIT = 10;
	localparam logic [NUM_W-1:0] NUM_MASK = '1;

	typedef struct packed {
		logic [REQ_W-1:0]  kind;
		logic [IDX_W-1:0]  index;
		logic [NUM_W-1:0]  number;
		logic [PRES_W-1:0] presence;
	} lookup_req_t;

	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  index;
		logic [NUM_W-1:0]  number;
		logic [PRES_W-1:0] presence;
	} lookup_res_t;

	// Table copy, register copy and the queue of matches still owed by the block.
	class match_scoreboard;
		logic [NUM_W-1:0]        num_tab [MAX_ENTRIES];
		logic signed [PRES_W-1:0] pres_tab [MAX_ENTRIES];
		logic [CNT_W-1:0]        dense_limit = '0;
		logic [CNT_W-1:0]        entry_count = '0;
		lookup_res_t             expected_matches [$];
		int                      mismatches = 0;

		function int live_count();
			return (entry_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(entry_count);
		endfunction

		function int live_dense();
			return (dense_limit > live_count()) ? live_count() : int'(dense_limit);
		endfunction

		function lookup_res_t entry_hit(int i);
			lookup_res_t h;
			h.found    = 1'b1;
			h.index    = i[IDX_W-1:0];
			h.number   = num_tab[i];
			h.presence = pres_tab[i];
			return h;
		endfunction

		function void predict_match(lookup_req_t r);
			lookup_res_t res;
			int cnt, dense, lo, hi, mid, k;
			res   = '0;
			cnt   = live_count();
			dense = live_dense();
			case (r.kind)
				REQ_LOAD: begin
					num_tab[r.index]  = r.number;
					pres_tab[r.index] = r.presence;
					return;
				end
				REQ_FIND: begin
					// dense range answers by position, without looking at the stored number
					if (r.number >= 1 && int'(r.number) - 1 < dense) begin
						res = entry_hit(int'(r.number) - 1);
					end else begin
						lo = dense;
						hi = cnt - 1;
						while (lo <= hi) begin
							mid = (lo + hi) / 2;
							if (num_tab[mid] < r.number) begin
								lo = mid + 1;
							end else if (num_tab[mid] > r.number) begin
								hi = mid - 1;
							end else begin
								res = entry_hit(mid);
								break;
							end
						end
					end
				end
				REQ_GET, REQ_NEXT: begin
					// get needs a negative code and scans from entry zero; next scans on
					// from the given entry whatever its sign
					if (int'(r.index) < cnt &&
					    (r.kind == REQ_NEXT || pres_tab[r.index][PRES_W-1])) begin
						for (k = (r.kind == REQ_GET) ? 0 : int'(r.index) + 1; k < cnt; k++) begin
							if (pres_tab[k] == pres_tab[r.index]) begin
								res = entry_hit(k);
								break;
							end
						end
					end
				end
			endcase
			expected_matches.push_back(res);
		endfunction

		function void check_match(lookup_res_t got);
			lookup_res_t want;
			if (expected_matches.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected match: found=%0d idx=%0d num=%0d pres=%0d",
						got.found, got.index, got.number, $signed(got.presence));
				return;
			end
			want = expected_matches.pop_front();
			if (got.found !== want.found || got.index !== want.index ||
			    got.number !== want.number || got.presence !== want.presence) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("mismatch: expected found=%0d idx=%0d num=%0d pres=%0d, got found=%0d idx=%0d num=%0d pres=%0d",
						want.found, want.index, want.number, $signed(want.presence),
						got.found, got.index, got.number, $signed(got.presence));
			end
		endfunction
	endclass

	// Clock, reset and every block input start at known values.
	logic                     clk            = 1'b0;
	logic                     arst_n         = 1'b0;
	logic                     in_valid       = 1'b0;
	logic [REQ_W-1:0]         req_type       = REQ_LOAD;
	logic [IDX_W-1:0]         entry_index    = '0;
	logic [NUM_W-1:0]         field_number   = '0;
	logic signed [PRES_W-1:0] presence       = '0;
	logic                     cfg_we         = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index      = CFG_DENSE_LIMIT;
	logic [CNT_W-1:0]         cfg_wdata      = '0;
	logic                     out_stall      = 1'b0;
	logic                     in_stall;
	logic                     out_valid;
	logic                     found;
	logic [IDX_W-1:0]         match_index;
	logic [NUM_W-1:0]         match_number;
	logic signed [PRES_W-1:0] match_presence;

	lookup_res_t     seen_match;
	match_scoreboard sb;

	int   send_idle_pct = 24;
	int   recv_idle_pct = 54;
	logic hold_req      = 1'b0;
	logic hold_done     = 1'b0;
	int   hold_left     = 0;
	int   cycle_count   = 0;

	int phase_dense [PHASES] = '{0, 37, 0, 256, 0, 10, 3, 200, 0};
	int phase_count [PHASES] = '{256, 100, 1, 256, 0, 255, 7, 220, 511};

	assign seen_match = {found, match_index, match_number, match_presence};

	field_table_lookup u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.entry_index    (entry_index),
		.field_number   (field_number),
		.presence       (presence),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.found          (found),
		.match_index    (match_index),
		.match_number   (match_number),
		.match_presence (match_presence)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Give up on a hung block well past the slowest correct run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: check the item taken at this edge, then pick the stall for the next one.
	// Hold off once for a long stretch when asked, so the block backs up into its input.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				sb.check_match(seen_match);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	function automatic lookup_req_t mk_req(logic [REQ_W-1:0] kind, int index, longint number,
		int pres);
		lookup_req_t r;
		r.kind     = kind;
		r.index    = index[IDX_W-1:0];
		r.number   = number[NUM_W-1:0];
		r.presence = pres[PRES_W-1:0];
		return r;
	endfunction

	// Offer one item, idling at random first; return at the edge that takes it.
	// Leave valid high so a following item goes out back to back.
	task automatic send_item(input lookup_req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= r.kind;
		entry_index  <= r.index;
		field_number <= r.number;
		presence     <= r.presence;
		do @(posedge clk); while (in_stall);
		sb.predict_match(r);
	endtask

	// Drop valid, wait for every owed match, then let any trailing load drain.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_matches.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write both registers on back-to-back edges; only call while idle.
	task automatic set_limits(input int dense, input int count);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DENSE_LIMIT;
		cfg_wdata <= dense[CNT_W-1:0];
		@(posedge clk);
		cfg_index <= CFG_ENTRY_COUNT;
		cfg_wdata <= count[CNT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.dense_limit = dense[CNT_W-1:0];
		sb.entry_count = count[CNT_W-1:0];
	endtask

	// Load all entries: index+1 below the dense limit, then a sorted run with wide gaps to
	// the end of the table, so every later window of limits searches sorted entries. About
	// half the codes come from a small pool of negative codes so oneof groups form.
	task automatic fill_table(input int dense);
		logic signed [PRES_W-1:0] codes [4];
		longint next_num, gap;
		lookup_req_t r;
		int i, v;
		for (i = 0; i < 4; i++) begin
			v = -int'($urandom_range(1, 32768));
			codes[i] = v[PRES_W-1:0];
		end
		gap = (longint'(NUM_MASK) - longint'(dense)) / longint'(MAX_ENTRIES - dense + 1);
		if (gap < 1)
			gap = 1;
		next_num = longint'(dense);
		for (i = 0; i < MAX_ENTRIES; i++) begin
			r.kind  = REQ_LOAD;
			r.index = i[IDX_W-1:0];
			if (i < dense) begin
				r.number = NUM_W'(i + 1);
			end else begin
				next_num += longint'($urandom_range(1, 32'(2 * gap - 1)));
				if (next_num > longint'(NUM_MASK))
					next_num = longint'(NUM_MASK);
				r.number = next_num[NUM_W-1:0];
			end
			if ($urandom_range(0, 99) < 55)
				r.presence = codes[$urandom_range(0, 3)];
			else
				r.presence = PRES_W'($urandom_range(0, 32767));
			send_item(r);
		end
	endtask

	// Mostly well-aimed requests: stored numbers, dense numbers and neighbors for finds,
	// live entries for oneof scans; the rest is stray loads and wild values.
	function automatic lookup_req_t random_request(int dense, int cnt);
		lookup_req_t r;
		int p, q, pick;
		r.kind     = REQ_LOAD;
		r.index    = IDX_W'($urandom);
		r.number   = NUM_W'($urandom);
		r.presence = PRES_W'($urandom);
		p = $urandom_range(0, 99);
		q = $urandom_range(0, 99);
		if (p < 8) begin
			r.kind = REQ_LOAD;
		end else if (p < 45) begin
			r.kind = REQ_FIND;
			pick = (cnt > dense) ? $urandom_range(dense, cnt - 1) : 0;
			if (q < 40 && cnt > dense)
				r.number = sb.num_tab[pick];
			else if (q < 55 && dense > 0)
				r.number = NUM_W'($urandom_range(1, dense));
			else if (q < 62)
				r.number = '0;
			else if (q < 75 && cnt > dense)
				r.number = NUM_W'(int'(sb.num_tab[pick]) + (q[0] ? 1 : -1));
		end else begin
			r.kind = (p < 72) ? REQ_GET : REQ_NEXT;
			if (cnt > 0 && q < 85)
				r.index = IDX_W'($urandom_range(0, cnt - 1));
		end
		return r;
	endfunction

	initial begin
		int p;
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: dense limit 4, 16 entries, one negative code shared by entries 0, 6
		// and 11 so a get-oneof must come back with index zero.
		set_limits(4, 16);
		fill_table(4);
		send_item(mk_req(REQ_LOAD, 0, 1, -32768));
		send_item(mk_req(REQ_LOAD, 6, longint'(sb.num_tab[6]), -32768));
		send_item(mk_req(REQ_LOAD, 11, longint'(sb.num_tab[11]), -32768));
		send_item(mk_req(REQ_LOAD, 12, longint'(sb.num_tab[12]), -1));
		send_item(mk_req(REQ_LOAD, 15, longint'(sb.num_tab[15]), 32767));
		send_item(mk_req(REQ_FIND, 0, 0, 0));
		send_item(mk_req(REQ_FIND, 0, 1, 0));
		send_item(mk_req(REQ_FIND, 0, 4, 0));
		send_item(mk_req(REQ_FIND, 0, 5, 0));
		send_item(mk_req(REQ_FIND, 0, longint'(sb.num_tab[4]), 0));
		send_item(mk_req(REQ_FIND, 0, longint'(sb.num_tab[15]), 0));
		send_item(mk_req(REQ_FIND, 255, longint'(NUM_MASK), -1));
		send_item(mk_req(REQ_GET, 11, 0, 0));
		send_item(mk_req(REQ_NEXT, 0, 0, 0));
		send_item(mk_req(REQ_NEXT, 11, 0, 0));
		send_item(mk_req(REQ_GET, 15, 0, 0));
		send_item(mk_req(REQ_NEXT, 15, 0, 0));
		send_item(mk_req(REQ_GET, 16, 0, 0));
		send_item(mk_req(REQ_NEXT, 255, 0, 0));
		send_item(mk_req(REQ_GET, 12, 0, 0));
		settle();

		// Dense limit above the count: clip it; hit by position, search nothing.
		set_limits(20, 10);
		send_item(mk_req(REQ_FIND, 0, 7, 0));
		send_item(mk_req(REQ_FIND, 0, 11, 0));
		send_item(mk_req(REQ_GET, 10, 0, 0));
		settle();

		// Both registers at their top: the count clips to the table size.
		set_limits(511, 511);
		send_item(mk_req(REQ_FIND, 0, 256, 0));
		send_item(mk_req(REQ_NEXT, 255, 0, 0));
		send_item(mk_req(REQ_GET, 255, 0, 0));
		settle();

		// Random phases over the loaded table: sender idles lightly then heavily while the
		// receiver does the reverse, then neither idles but for one long receiver hold-off.
		for (p = 0; p < PHASES; p++) begin
			if (p < 3) begin
				send_idle_pct = 24;
				recv_idle_pct = 54;
			end else if (p < 6) begin
				send_idle_pct = 54;
				recv_idle_pct = 24;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			set_limits(phase_dense[p], phase_count[p]);
			if (p == 6)
				hold_req <= 1'b1;
			repeat (PHASE_ITEMS) send_item(random_request(sb.live_dense(), sb.live_count()));
			settle();
		end

		if (sb.mismatches == 0 && sb.expected_matches.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ftl_pkg.sv
rtl/core/ftl_ram.sv
rtl/core/ftl_dp.sv
rtl/core/ftl_ctrl.sv
rtl/core/field_table_lookup.sv
rtl/core/ftl_checker.sv
test/tb_top.sv
